FILE: src/rectified_mean_current_meter_unit_defines.svh
// Assertion macros for the rectified mean current meter.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef RECTIFIED_MEAN_CURRENT_METER_UNIT_DEFINES_SVH
`define RECTIFIED_MEAN_CURRENT_METER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define RMCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmcm assertion failed");

// Next-cycle implication
`define RMCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmcm assertion failed");

`else

`define RMCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RMCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/rmcm_pkg.sv
package rmcm_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 12;
    localparam int THR_BITS    = 12;
    localparam int CNT_BITS    = 10;
    localparam int GAIN_BITS   = 16;
    localparam int SUM_BITS    = 22;
    localparam int OUT_BITS    = 22;
    localparam int GAIN_FRAC   = 16;
    localparam int CFG_DATA_BITS = 16;

    // Longest window the counter supports
    localparam int WINDOW_MAX  = 1023;

    // Register reset values
    localparam logic [SAMPLE_BITS-1:0] ADC_OFFSET_RST   = SAMPLE_BITS'(1930);
    localparam logic [THR_BITS-1:0]    REJECT_THR_RST   = THR_BITS'(120);
    localparam logic [CNT_BITS-1:0]    WINDOW_LEN_RST   = CNT_BITS'(200);
    localparam logic [GAIN_BITS-1:0]   CURRENT_GAIN_RST = GAIN_BITS'(6465);

    // Register indexes
    typedef enum logic [1:0] {
        CFG_ADC_OFFSET   = 2'd0,
        CFG_REJECT_THR   = 2'd1,
        CFG_WINDOW_LEN   = 2'd2,
        CFG_CURRENT_GAIN = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_cfg_index               index;
        logic [CFG_DATA_BITS-1:0] value;
    } t_cfg_word;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
    } t_sample_word;

    typedef struct packed {
        logic [OUT_BITS-1:0]    current_ma;
        logic                   rejected;
        logic [SAMPLE_BITS-1:0] peak_max;
        logic [SAMPLE_BITS-1:0] peak_min;
    } t_result_word;

    // Live register values
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] adc_offset;
        logic [THR_BITS-1:0]    reject_threshold;
        logic [CNT_BITS-1:0]    window_length;
        logic [GAIN_BITS-1:0]   current_gain;
    } t_cfg_regs;

    // Finished window handed from accumulator to result stage
    typedef struct packed {
        logic [SUM_BITS-1:0]    dev_sum;
        logic [SAMPLE_BITS-1:0] high;
        logic [SAMPLE_BITS-1:0] low;
    } t_window;

endpackage

FILE: src/rmcm_stream_if.sv
interface rmcm_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/rmcm_cfg_regs.sv
module rmcm_cfg_regs
    import rmcm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rmcm_stream_if.sink  i_cfg,
    output t_cfg_regs    o_regs
);

    t_cfg_regs r_regs;

    // Always take writes
    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    // Decode index and store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.adc_offset       <= ADC_OFFSET_RST;
            r_regs.reject_threshold <= REJECT_THR_RST;
            r_regs.window_length    <= WINDOW_LEN_RST;
            r_regs.current_gain     <= CURRENT_GAIN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_ADC_OFFSET: begin
                    r_regs.adc_offset <= i_cfg.data.value[SAMPLE_BITS-1:0];
                end
                CFG_REJECT_THR: begin
                    r_regs.reject_threshold <= i_cfg.data.value[THR_BITS-1:0];
                end
                CFG_WINDOW_LEN: begin
                    r_regs.window_length <= i_cfg.data.value[CNT_BITS-1:0];
                end
                CFG_CURRENT_GAIN: begin
                    r_regs.current_gain <= i_cfg.data.value[GAIN_BITS-1:0];
                end
            endcase
        end
    end

endmodule

FILE: src/rmcm_accum.sv
`include "rectified_mean_current_meter_unit_defines.svh"

module rmcm_accum
    import rmcm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg_regs    i_regs,
    rmcm_stream_if.sink  i_sample,
    output t_window      o_window,
    output logic         o_window_valid,
    input  logic         i_window_take
);

    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_sample;

    logic [CNT_BITS-1:0]    r_count;
    logic [SUM_BITS-1:0]    r_sum;
    logic [SAMPLE_BITS-1:0] r_high;
    logic [SAMPLE_BITS-1:0] r_low;

    logic                   r_win_valid;
    t_window                r_win;

    logic [CNT_BITS-1:0]    len;
    logic                   win_end;
    logic                   s1_adv;
    logic [SAMPLE_BITS-1:0] dev;
    logic [SUM_BITS:0]      sum_ext;
    logic [SUM_BITS-1:0]    n_sum;
    logic [SAMPLE_BITS-1:0] n_high;
    logic [SAMPLE_BITS-1:0] n_low;

    // Clamp window length to 1..WINDOW_MAX
    always_comb begin
        len = i_regs.window_length;
        if (len == '0) begin
            len = CNT_BITS'(1);
        end
        if (32'(len) > WINDOW_MAX) begin
            len = CNT_BITS'(WINDOW_MAX);
        end
    end

    assign win_end = ({1'b0, r_count} + (CNT_BITS+1)'(1)) >= {1'b0, len};

    // Stall only when this sample closes a window and the last record still waits
    assign s1_adv         = r_s1_valid && (!win_end || !r_win_valid || i_window_take);
    assign i_sample.ready = !r_s1_valid || s1_adv;

    // Rectify and accumulate with saturation
    assign dev = (r_s1_sample >= i_regs.adc_offset) ? (r_s1_sample - i_regs.adc_offset)
                                                    : (i_regs.adc_offset - r_s1_sample);
    assign sum_ext = {1'b0, r_sum} + (SUM_BITS+1)'(dev);
    assign n_sum   = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
    assign n_high  = (r_s1_sample > r_high) ? r_s1_sample : r_high;
    assign n_low   = (r_s1_sample < r_low) ? r_s1_sample : r_low;

    assign o_window       = r_win;
    assign o_window_valid = r_win_valid;

    // Control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_high      <= '0;
            r_low       <= '1;
            r_win_valid <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_s1_valid <= i_sample.valid;
            end
            if (s1_adv && win_end) begin
                r_win_valid <= 1'b1;
            end else if (i_window_take) begin
                r_win_valid <= 1'b0;
            end
            if (s1_adv) begin
                if (win_end) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_high  <= '0;
                    r_low   <= '1;
                end else begin
                    r_count <= r_count + CNT_BITS'(1);
                    r_sum   <= n_sum;
                    r_high  <= n_high;
                    r_low   <= n_low;
                end
            end
        end
    end

    // Payload: input word and finished window record
    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_s1_sample <= i_sample.data.sample;
        end
        if (s1_adv && win_end) begin
            r_win.dev_sum <= n_sum;
            r_win.high    <= n_high;
            r_win.low     <= n_low;
        end
    end

    `RMCM_ASSERT_NXT(a_window_clears, i_clk, i_rst_n, s1_adv && win_end, (r_count == '0) && (r_sum == '0))
    `RMCM_ASSERT_IMP(a_high_over_low, i_clk, i_rst_n, r_count != '0, r_high >= r_low)
    `RMCM_ASSERT_IMP(a_record_order, i_clk, i_rst_n, r_win_valid, r_win.high >= r_win.low)

endmodule

FILE: src/rmcm_result.sv
`include "rectified_mean_current_meter_unit_defines.svh"

module rmcm_result
    import rmcm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg_regs      i_regs,
    input  t_window        i_window,
    input  logic           i_window_valid,
    output logic           o_window_take,
    rmcm_stream_if.source  o_result
);

    localparam int PROD_BITS = SUM_BITS + GAIN_BITS;

    logic                   r_out_valid;
    t_result_word           r_out;
    logic [OUT_BITS-1:0]    r_last_good;

    logic                   out_free;
    logic [PROD_BITS-1:0]   prod;
    logic [OUT_BITS-1:0]    cur;
    logic [SAMPLE_BITS:0]   hl_sum;
    logic [SAMPLE_BITS:0]   off2;
    logic [THR_BITS:0]      thr2;
    logic                   reject;

    assign out_free      = !r_out_valid || o_result.ready;
    assign o_window_take = i_window_valid && out_free;

    // Scale summed deviation by Q16 gain; the top bits never exceed the output range
    assign prod = PROD_BITS'(i_window.dev_sum) * PROD_BITS'(i_regs.current_gain);
    assign cur  = prod[GAIN_FRAC +: OUT_BITS];

    // Midpoint check: |high + low - 2*offset| > 2*threshold
    assign hl_sum = {1'b0, i_window.high} + {1'b0, i_window.low};
    assign off2   = {i_regs.adc_offset, 1'b0};
    assign thr2   = {i_regs.reject_threshold, 1'b0};
    assign reject = (hl_sum >= off2) ? ((hl_sum - off2) > thr2) : ((off2 - hl_sum) > thr2);

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // Output valid and held good value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_good <= '0;
        end else begin
            if (o_window_take) begin
                r_out_valid <= 1'b1;
                if (!reject) begin
                    r_last_good <= cur;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (o_window_take) begin
            r_out.current_ma <= reject ? r_last_good : cur;
            r_out.rejected   <= reject;
            r_out.peak_max   <= i_window.high;
            r_out.peak_min   <= i_window.low;
        end
    end

    `RMCM_ASSERT_IMP(a_out_tracks_good, i_clk, i_rst_n, r_out_valid, r_out.current_ma == r_last_good)
    `RMCM_ASSERT_IMP(a_out_peaks, i_clk, i_rst_n, r_out_valid, r_out.peak_max >= r_out.peak_min)
    `RMCM_ASSERT_NXT(a_reject_holds, i_clk, i_rst_n, o_window_take && reject, r_last_good == $past(r_last_good))

endmodule

FILE: src/rectified_mean_current_meter_unit.sv
// Channel    Dir  Word           Handshake
// i_sample   in   t_sample_word  valid/ready, one ADC code per word
// i_cfg      in   t_cfg_word     valid/ready, register index and value
// o_result   out  t_result_word  valid/ready, one word per closed window
//
// Takes one sample per cycle unless stalled; an accepted sample is registered
// before the accumulator folds it in, and a closed window passes the record and
// output registers; the 22x16 gain multiply sits before the output register.
// Synchronous active-low reset loads register defaults and clears the window.
// A waiting result holds the output register while samples keep accumulating;
// input stalls only if a window closes while the previous record still waits.
module rectified_mean_current_meter_unit
    import rmcm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    rmcm_stream_if.sink    i_sample,
    rmcm_stream_if.sink    i_cfg,
    rmcm_stream_if.source  o_result
);

    t_cfg_regs cfg_regs;
    t_window   window;
    logic      window_valid;
    logic      window_take;

    // Configuration registers
    rmcm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (cfg_regs)
    );

    // Rectify, accumulate and track peaks
    rmcm_accum u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_regs         (cfg_regs),
        .i_sample       (i_sample),
        .o_window       (window),
        .o_window_valid (window_valid),
        .i_window_take  (window_take)
    );

    // Scale, check midpoint and register result
    rmcm_result u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_regs         (cfg_regs),
        .i_window       (window),
        .i_window_valid (window_valid),
        .o_window_take  (window_take),
        .o_result       (o_result)
    );

endmodule

FILE: bench/rectified_mean_current_meter_unit_tb.sv
`timescale 1ns / 1ps

module rectified_mean_current_meter_unit_tb
    import rmcm_pkg::*;
();

    localparam int  PLAN_ROWS      = 29;
    localparam int  RANDOM_SAMPLES = 580;
    localparam int  MIN_WINDOWS    = 40;
    localparam int  LONG_PHASE     = 2;
    localparam int  LONG_LEN       = 300;
    localparam int  QUIET_CYCLES   = 4;
    localparam int  TAIL_CYCLES    = 12;
    localparam int  WATCHDOG_LIMIT = 1000;
    localparam longint SUM_CAP     = (longint'(1) << SUM_BITS) - 1;
    localparam longint OUT_CAP     = (longint'(1) << OUT_BITS) - 1;

    typedef enum int {
        SHAPE_BAND,
        SHAPE_NOISE,
        SHAPE_RAIL,
        SHAPE_SKEW
    } t_shape;

    // One directed step: a register write or a sample, optionally with a fixed result
    typedef struct packed {
        logic                   is_cfg;
        t_cfg_index             idx;
        logic [CFG_DATA_BITS-1:0] value;
        logic                   pinned;
        t_result_word           want;
    } t_plan_row;

    logic clk;
    logic rst_n;

    rmcm_stream_if #(.t_payload(t_sample_word)) sample_bus ();
    rmcm_stream_if #(.t_payload(t_cfg_word))    cfg_bus ();
    rmcm_stream_if #(.t_payload(t_result_word)) result_bus ();

    rectified_mean_current_meter_unit u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    // Meter model: registers and open-window state
    logic [SAMPLE_BITS-1:0] m_offset;
    logic [THR_BITS-1:0]    m_thresh;
    logic [CNT_BITS-1:0]    m_len;
    logic [GAIN_BITS-1:0]   m_gain;
    logic [CNT_BITS-1:0]    acc_count;
    logic [SUM_BITS-1:0]    acc_sum;
    logic [SAMPLE_BITS-1:0] acc_high;
    logic [SAMPLE_BITS-1:0] acc_low;
    logic [OUT_BITS-1:0]    held_current;

    t_result_word pending_windows [$];
    t_plan_row    plan [PLAN_ROWS];

    int  errors;
    int  samples_fed;
    int  random_fed;
    int  regs_written;
    int  windows_seen;
    int  rejects_seen;
    int  quiet_cycles;
    bit  drain_steady;

    // Clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Meter model: fold one sample into the window, close it on its last sample
    task automatic accumulate_sample(input logic [SAMPLE_BITS-1:0] s,
                                     output bit closed, output t_result_word word);
        int unsigned span;
        int unsigned dev;
        longint      total;
        longint      mid;
        longint      prod;
        logic [OUT_BITS-1:0] cur;
        bit          rej;
        span = (m_len == 0) ? 1 : int'(m_len);
        if (span > WINDOW_MAX) span = WINDOW_MAX;
        closed = 1'b0;
        word   = '0;
        if (s > acc_high) acc_high = s;
        if (s < acc_low) acc_low = s;
        dev = (s >= m_offset) ? int'(s) - int'(m_offset) : int'(m_offset) - int'(s);
        total = longint'(acc_sum) + longint'(dev);
        acc_sum = (total > SUM_CAP) ? SUM_BITS'(SUM_CAP) : SUM_BITS'(total);
        if (int'(acc_count) + 1 < int'(span)) begin
            acc_count = acc_count + 1'b1;
            return;
        end
        // Midpoint check, then scale or hold
        mid = longint'(acc_high) + longint'(acc_low) - 2 * longint'(m_offset);
        if (mid < 0) mid = -mid;
        rej = (mid > 2 * longint'(m_thresh));
        if (rej) begin
            cur = held_current;
        end else begin
            prod = (longint'(acc_sum) * longint'(m_gain)) >>> GAIN_FRAC;
            if (prod > OUT_CAP) prod = OUT_CAP;
            cur = OUT_BITS'(prod);
            held_current = cur;
        end
        word.current_ma = cur;
        word.rejected   = rej;
        word.peak_max   = acc_high;
        word.peak_min   = acc_low;
        closed = 1'b1;
        acc_count = '0;
        acc_sum   = '0;
        acc_high  = '0;
        acc_low   = '1;
    endtask

    function automatic t_plan_row cfg_row(input t_cfg_index idx,
                                          input logic [CFG_DATA_BITS-1:0] v);
        t_plan_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = v;
        return row;
    endfunction

    function automatic t_plan_row smp_row(input int s);
        t_plan_row row;
        row = '0;
        row.idx   = CFG_ADC_OFFSET;
        row.value = CFG_DATA_BITS'(s);
        return row;
    endfunction

    function automatic t_plan_row pin_row(input int s, input int cur, input bit rej,
                                          input int hi, input int lo);
        t_plan_row row;
        row = smp_row(s);
        row.pinned = 1'b1;
        row.want.current_ma = OUT_BITS'(cur);
        row.want.rejected   = rej;
        row.want.peak_max   = SAMPLE_BITS'(hi);
        row.want.peak_min   = SAMPLE_BITS'(lo);
        return row;
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // 12-bit level with random junk in the upper bits of the data word
    function automatic logic [CFG_DATA_BITS-1:0] pick_level(input int lo, input int hi);
        int r;
        logic [SAMPLE_BITS-1:0] lvl;
        r = $urandom_range(0, 99);
        if (r < 80)      lvl = SAMPLE_BITS'($urandom_range(lo, hi));
        else if (r < 88) lvl = '0;
        else if (r < 96) lvl = '1;
        else             lvl = SAMPLE_BITS'($urandom);
        return {4'($urandom), lvl};
    endfunction

    function automatic logic [CNT_BITS-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return CNT_BITS'($urandom_range(1, 8));
        if (r < 80) return CNT_BITS'($urandom_range(9, 32));
        if (r < 95) return CNT_BITS'($urandom_range(33, 100));
        return '0;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] make_sample(input t_shape shape,
                                                          input int amp, input int bias);
        int v;
        case (shape)
            SHAPE_BAND: v = int'(m_offset) + bias + int'($urandom_range(0, 2 * amp)) - amp;
            SHAPE_NOISE: v = int'($urandom_range(0, 4095));
            SHAPE_RAIL: v = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095)) :
                            ($urandom_range(0, 1) ? 4095 : 0);
            default: v = int'(m_offset) + int'($urandom_range(0, amp));
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_BITS'(v);
    endfunction

    // Drop sample valid and wait until every open result has been taken
    task automatic wait_quiet();
        sample_bus.valid <= 1'b0;
        repeat (QUIET_CYCLES) @(posedge clk);
        while (pending_windows.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] v);
        wait_quiet();
        cfg_bus.valid      <= 1'b1;
        cfg_bus.data.index <= idx;
        cfg_bus.data.value <= v;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_ADC_OFFSET:   m_offset = v[SAMPLE_BITS-1:0];
            CFG_REJECT_THR:   m_thresh = v[THR_BITS-1:0];
            CFG_WINDOW_LEN:   m_len    = v[CNT_BITS-1:0];
            CFG_CURRENT_GAIN: m_gain   = v[GAIN_BITS-1:0];
            default: ;
        endcase
        regs_written++;
    endtask

    // Send one sample word and queue what it closes
    task automatic feed_sample(input logic [SAMPLE_BITS-1:0] s, input bit gappy,
                               input bit pinned, input t_result_word want);
        int gap;
        bit closed;
        t_result_word word;
        gap = gappy ? pick_gap() : 0;
        if (gap > 0) begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid       <= 1'b1;
        sample_bus.data.sample <= s;
        do @(posedge clk); while (!sample_bus.ready);
        samples_fed++;
        accumulate_sample(s, closed, word);
        if (pinned) begin
            pending_windows.push_back(want);
        end else if (closed) begin
            pending_windows.push_back(word);
        end
        if (closed) begin
            windows_seen++;
            if (word.rejected) rejects_seen++;
        end
    endtask

    // Result side: random back-pressure, steady when asked
    initial begin : drive_result_ready
        int stall_left;
        int r;
        stall_left = 0;
        result_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                result_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end else if (drain_steady) begin
                result_bus.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    result_bus.ready <= 1'b1;
                end else if (r < 93) begin
                    result_bus.ready <= 1'b0;
                    stall_left = $urandom_range(1, 3) - 1;
                end else begin
                    result_bus.ready <= 1'b0;
                    stall_left = $urandom_range(10, 50) - 1;
                end
            end
        end
    end

    // Compare each taken result word with the oldest pending window
    always @(posedge clk) begin : check_results
        t_result_word want;
        if (rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_windows.size() == 0) begin
                $error("result word with no window pending: %h", result_bus.data);
                errors++;
            end else begin
                want = pending_windows.pop_front();
                if (result_bus.data.current_ma !== want.current_ma) begin
                    $error("current_ma: expected %0d, got %0d",
                           want.current_ma, result_bus.data.current_ma);
                    errors++;
                end
                if (result_bus.data.rejected !== want.rejected) begin
                    $error("rejected: expected %0d, got %0d",
                           want.rejected, result_bus.data.rejected);
                    errors++;
                end
                if (result_bus.data.peak_max !== want.peak_max) begin
                    $error("peak_max: expected %0d, got %0d",
                           want.peak_max, result_bus.data.peak_max);
                    errors++;
                end
                if (result_bus.data.peak_min !== want.peak_min) begin
                    $error("peak_min: expected %0d, got %0d",
                           want.peak_min, result_bus.data.peak_min);
                    errors++;
                end
            end
        end
    end

    // Watchdog: stop a run in which no word moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((sample_bus.valid && sample_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
                (result_bus.valid && result_bus.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : run
        int     phase;
        int     span;
        int     count;
        int     amp;
        int     bias;
        int     r;
        t_shape shape;
        bit     gappy;
        t_result_word none;

        none = '0;
        errors = 0;
        samples_fed = 0;
        random_fed = 0;
        regs_written = 0;
        windows_seen = 0;
        rejects_seen = 0;
        quiet_cycles = 0;
        drain_steady = 1'b0;

        rst_n = 1'b0;
        sample_bus.valid = 1'b0;
        sample_bus.data  = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.data     = '0;

        // Model at its reset values
        m_offset     = ADC_OFFSET_RST;
        m_thresh     = REJECT_THR_RST;
        m_len        = WINDOW_LEN_RST;
        m_gain       = CURRENT_GAIN_RST;
        acc_count    = '0;
        acc_sum      = '0;
        acc_high     = '0;
        acc_low      = '1;
        held_current = '0;

        // Directed steps: reset values, rails, threshold edges, length corners
        plan = '{
            cfg_row(CFG_WINDOW_LEN, 16'hFC01),          // upper bits dropped: length 1
            pin_row(1930, 0, 1'b0, 1930, 1930),          // default offset gives zero
            pin_row(4095, 0, 1'b1, 4095, 4095),          // far off center, held zero
            pin_row(0, 0, 1'b1, 0, 0),
            smp_row(2050),                               // midpoint exactly at threshold
            smp_row(2051),                               // one past it: rejected
            cfg_row(CFG_REJECT_THR, 16'hFFFF),
            cfg_row(CFG_CURRENT_GAIN, 16'hFFFF),
            cfg_row(CFG_ADC_OFFSET, 16'h0000),
            smp_row(4095),                               // largest deviation, top rail
            cfg_row(CFG_ADC_OFFSET, 16'hFFFF),
            smp_row(0),                                  // largest deviation, bottom rail
            cfg_row(CFG_REJECT_THR, 16'hF000),
            pin_row(4095, 0, 1'b0, 4095, 4095),          // zero threshold, centered
            pin_row(4094, 0, 1'b1, 4094, 4094),          // zero threshold, off by one
            cfg_row(CFG_WINDOW_LEN, 16'h0000),           // zero length acts as one
            pin_row(4095, 0, 1'b0, 4095, 4095),
            cfg_row(CFG_ADC_OFFSET, 16'h0800),
            cfg_row(CFG_REJECT_THR, 16'h0FFF),
            cfg_row(CFG_WINDOW_LEN, 16'h0005),
            smp_row(0),
            smp_row(4095),
            cfg_row(CFG_WINDOW_LEN, 16'h0002),           // shortened mid-window
            smp_row(2048),                               // closes at once
            cfg_row(CFG_CURRENT_GAIN, 16'h0000),
            cfg_row(CFG_WINDOW_LEN, 16'hFC03),
            smp_row(0),
            smp_row(4095),
            pin_row(1234, 0, 1'b0, 4095, 0)              // zero gain
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (plan[i].is_cfg) begin
                write_register(plan[i].idx, plan[i].value);
            end else begin
                feed_sample(plan[i].value[SAMPLE_BITS-1:0], 1'b1, plan[i].pinned,
                            plan[i].want);
            end
        end

        // Random phases: new settings, then a burst of samples of one shape
        phase = 0;
        while (random_fed < RANDOM_SAMPLES || windows_seen < MIN_WINDOWS) begin
            if ($urandom_range(0, 1)) write_register(CFG_ADC_OFFSET, pick_level(1500, 2600));
            if ($urandom_range(0, 1)) write_register(CFG_REJECT_THR, pick_level(0, 400));
            if (phase == LONG_PHASE) begin
                write_register(CFG_WINDOW_LEN, {6'($urandom), CNT_BITS'(LONG_LEN)});
            end else if (phase < LONG_PHASE || int'(m_len) > 100 || $urandom_range(0, 1)) begin
                write_register(CFG_WINDOW_LEN, {6'($urandom), pick_length()});
            end
            if ($urandom_range(0, 1)) begin
                r = $urandom_range(0, 99);
                if (r < 70)      write_register(CFG_CURRENT_GAIN, 16'($urandom));
                else if (r < 80) write_register(CFG_CURRENT_GAIN, 16'h0000);
                else if (r < 90) write_register(CFG_CURRENT_GAIN, 16'hFFFF);
                else             write_register(CFG_CURRENT_GAIN, CURRENT_GAIN_RST);
            end

            span = (m_len == 0) ? 1 : int'(m_len);
            if (span > 100) count = span + $urandom_range(0, 8);
            else            count = $urandom_range(1, 3 * span + 2);

            r = $urandom_range(0, 99);
            if (r < 70)      shape = SHAPE_BAND;
            else if (r < 82) shape = SHAPE_NOISE;
            else if (r < 90) shape = SHAPE_RAIL;
            else             shape = SHAPE_SKEW;
            amp  = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 300) :
                                                  $urandom_range(1, 2047);
            bias = 0;
            if ($urandom_range(0, 99) >= 70) begin
                bias = int'($urandom_range(0, 4 * int'(m_thresh) + 20)) -
                       (2 * int'(m_thresh) + 10);
            end
            gappy        = ($urandom_range(0, 3) != 0);
            drain_steady = ($urandom_range(0, 3) == 0);

            for (int k = 0; k < count; k++) begin
                feed_sample(make_sample(shape, amp, bias), gappy, 1'b0, none);
            end
            random_fed += count;
            phase++;
        end

        // Drain and give a late extra word time to show up
        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d samples over %0d random phases, %0d register writes",
                 samples_fed, phase, regs_written);
        $display("tb: %0d windows closed, %0d of them rejected", windows_seen, rejects_seen);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
